// ----- hw/rtl/text_token_boundary_scanner_top_defines.svh -----
// ----------------------------------------------------------------------------
// Text token boundary scanner assertion macros
// Shared assertion forms used by the scanner modules.
// ----------------------------------------------------------------------------
`ifndef TEXT_TOKEN_BOUNDARY_SCANNER_TOP_DEFINES_SVH
`define TEXT_TOKEN_BOUNDARY_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TBS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TBS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/tbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Text token boundary scanner package
// Shared constants, token types and helpers for the scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbs_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int FIFO_DEPTH      = 4;
	localparam int TOKEN_BITS      = 32;
	localparam int WIDE_BITS       = 65;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_X    = 8'h58;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_X   = 8'h78;
	localparam logic [7:0] CH_LOW_Z   = 8'h7A;

	typedef enum logic [2:0] {
		KIND_WORD   = 3'd0,
		KIND_STRING = 3'd1,
		KIND_SYMBOL = 3'd2,
		KIND_UNTERM = 3'd3,
		KIND_END    = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [TOKEN_BITS-1:0] start;
		logic [TOKEN_BITS-1:0] length;
		logic                  last;
	} token_t;

	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} push_t;

	function automatic logic [TOKEN_BITS-1:0] clip_token(input logic [WIDE_BITS-1:0] v);
		if (|v[WIDE_BITS-1:TOKEN_BITS]) begin
			return '1;
		end
		return v[TOKEN_BITS-1:0];
	endfunction

endpackage

// ----- hw/rtl/tbs_scan.sv -----
// ----------------------------------------------------------------------------
// Text token boundary scanner: scan stage
// Classifies one byte against the scan mode and produces up to two tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_token_boundary_scanner_top_defines.svh"

module tbs_scan #(
	parameter int OFFSET_BITS = tbs_pkg::OFFSET_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 process,
	input  logic [7:0]           text_byte_s1,
	output tbs_pkg::push_t       push
);

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_WORD    = 3'd2,
		MODE_STRING  = 3'd3,
		MODE_ESC     = 3'd4,
		MODE_HEX     = 3'd5
	} mode_t;

	mode_t                        mode_q;
	mode_t                        mode_d;
	logic [OFFSET_BITS-1:0]       off_q;
	logic [OFFSET_BITS-1:0]       open_q;
	logic [OFFSET_BITS-1:0]       open_d;
	logic [OFFSET_BITS-1:0]       len_open;
	logic [tbs_pkg::WIDE_BITS-1:0] len_str;
	logic                         is_blank;
	logic                         is_word;
	logic                         idle_emit;
	tbs_pkg::kind_t               idle_kind;
	mode_t                        idle_mode;
	logic                         idle_open;
	tbs_pkg::token_t              idle_tok;
	tbs_pkg::token_t              r0;
	tbs_pkg::token_t              r1;
	logic [1:0]                   n;

	function automatic tbs_pkg::token_t make_tok(
		input tbs_pkg::kind_t                kind,
		input logic [tbs_pkg::WIDE_BITS-1:0] start,
		input logic [tbs_pkg::WIDE_BITS-1:0] len
	);
		tbs_pkg::token_t t;
		t.kind   = kind;
		t.start  = tbs_pkg::clip_token(start);
		t.length = tbs_pkg::clip_token(len);
		t.last   = 1'b0;
		return t;
	endfunction

	assign is_blank = (text_byte_s1 == tbs_pkg::CH_SPACE) || (text_byte_s1 == tbs_pkg::CH_TAB)
		|| (text_byte_s1 == tbs_pkg::CH_LF) || (text_byte_s1 == tbs_pkg::CH_CR);

	assign is_word = text_byte_s1 inside {[tbs_pkg::CH_LOW_A:tbs_pkg::CH_LOW_Z],
		[tbs_pkg::CH_UP_A:tbs_pkg::CH_UP_Z], [tbs_pkg::CH_DIGIT_0:tbs_pkg::CH_DIGIT_9],
		tbs_pkg::CH_MINUS, tbs_pkg::CH_DOT, tbs_pkg::CH_UNDER};

	assign len_open = off_q - open_q;

	// A closed string counts its closing quote, unless the length is already at its ceiling.
	assign len_str = (OFFSET_BITS == 64 && (&len_open)) ? tbs_pkg::WIDE_BITS'(len_open)
		: tbs_pkg::WIDE_BITS'(len_open) + tbs_pkg::WIDE_BITS'(1);

	always_comb begin
		idle_emit = 1'b0;
		idle_kind = tbs_pkg::KIND_SYMBOL;
		idle_mode = MODE_IDLE;
		idle_open = 1'b0;
		if (text_byte_s1 == tbs_pkg::CH_NUL) begin
			idle_emit = 1'b1;
			idle_kind = tbs_pkg::KIND_END;
		end else if (is_blank) begin
			idle_mode = MODE_IDLE;
		end else if (text_byte_s1 == tbs_pkg::CH_HASH) begin
			idle_mode = MODE_COMMENT;
		end else if (text_byte_s1 == tbs_pkg::CH_QUOTE) begin
			idle_mode = MODE_STRING;
			idle_open = 1'b1;
		end else if (is_word) begin
			idle_mode = MODE_WORD;
			idle_open = 1'b1;
		end else begin
			idle_emit = 1'b1;
		end
		idle_tok = make_tok(idle_kind, tbs_pkg::WIDE_BITS'(off_q),
			(idle_kind == tbs_pkg::KIND_END) ? '0 : tbs_pkg::WIDE_BITS'(1));
	end

	always_comb begin
		r0     = '0;
		r1     = '0;
		n      = 2'd0;
		mode_d = mode_q;
		open_d = open_q;
		case (mode_q)
			MODE_COMMENT: begin
				if (text_byte_s1 == tbs_pkg::CH_NUL) begin
					r0 = idle_tok;
					n  = 2'd1;
				end else if (text_byte_s1 == tbs_pkg::CH_LF) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_WORD: begin
				if (!is_word) begin
					r0     = make_tok(tbs_pkg::KIND_WORD, tbs_pkg::WIDE_BITS'(open_q),
						tbs_pkg::WIDE_BITS'(len_open));
					r1     = idle_tok;
					n      = idle_emit ? 2'd2 : 2'd1;
					mode_d = idle_mode;
					if (idle_open) begin
						open_d = off_q;
					end
				end
			end
			MODE_STRING, MODE_ESC, MODE_HEX: begin
				if (text_byte_s1 == tbs_pkg::CH_NUL) begin
					r0 = make_tok(tbs_pkg::KIND_UNTERM, tbs_pkg::WIDE_BITS'(open_q),
						tbs_pkg::WIDE_BITS'(len_open));
					r1 = idle_tok;
					n  = 2'd2;
				end else if (mode_q == MODE_ESC) begin
					mode_d = (text_byte_s1 == tbs_pkg::CH_LOW_X || text_byte_s1 == tbs_pkg::CH_UP_X)
						? MODE_HEX : MODE_STRING;
				end else if (mode_q == MODE_HEX) begin
					mode_d = MODE_STRING;
				end else if (text_byte_s1 == tbs_pkg::CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else if (text_byte_s1 == tbs_pkg::CH_QUOTE) begin
					r0     = make_tok(tbs_pkg::KIND_STRING, tbs_pkg::WIDE_BITS'(open_q), len_str);
					n      = 2'd1;
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				r0     = idle_tok;
				n      = idle_emit ? 2'd1 : 2'd0;
				mode_d = idle_mode;
				if (idle_open) begin
					open_d = off_q;
				end
			end
		endcase
		if (n == 2'd2) begin
			r1.last = 1'b1;
		end else if (n == 2'd1) begin
			r0.last = 1'b1;
		end
	end

	assign push.count  = process ? n : 2'd0;
	assign push.first  = r0;
	assign push.second = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			off_q  <= '0;
			open_q <= '0;
		end else if (process) begin
			if (text_byte_s1 == tbs_pkg::CH_NUL) begin
				mode_q <= MODE_IDLE;
				off_q  <= '0;
				open_q <= '0;
			end else begin
				mode_q <= mode_d;
				open_q <= open_d;
				if (off_q != '1) begin
					off_q <= off_q + 1'b1;
				end
			end
		end
	end

	`TBS_ASSERT_NXT(a_end_clears, process && text_byte_s1 == tbs_pkg::CH_NUL,
		off_q == '0 && open_q == '0 && mode_q == MODE_IDLE, "End of text did not clear the scan state.")
	`TBS_ASSERT_NXT(a_off_step, process && text_byte_s1 != tbs_pkg::CH_NUL && off_q != '1,
		off_q == $past(off_q) + 1'b1, "The byte offset did not advance by one.")
	`TBS_ASSERT_IMP(a_open_le_off, 1'b1, open_q <= off_q, "An open token starts beyond the offset.")

endmodule

// ----- hw/rtl/tbs_fifo.sv -----
// ----------------------------------------------------------------------------
// Text token boundary scanner: token queue
// Small register queue that takes up to two tokens a cycle and gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_token_boundary_scanner_top_defines.svh"

module tbs_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  tbs_pkg::push_t  push,
	input  logic            pop,
	output logic            has_room,
	output logic            not_empty,
	output tbs_pkg::token_t head
);

	localparam int Depth   = tbs_pkg::FIFO_DEPTH;
	localparam int PtrBits = $clog2(Depth);
	localparam int CntBits = $clog2(Depth + 1);

	tbs_pkg::token_t      mem_q [Depth];
	logic [PtrBits-1:0]   rd_q;
	logic [PtrBits-1:0]   wr_q;
	logic [PtrBits-1:0]   wr_next;
	logic [CntBits-1:0]   cnt_q;

	assign wr_next   = wr_q + 1'b1;
	assign has_room  = cnt_q <= CntBits'(Depth - 2);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			rd_q  <= rd_q + PtrBits'(pop);
			wr_q  <= wr_q + PtrBits'(push.count);
			cnt_q <= cnt_q + CntBits'(push.count) - CntBits'(pop);
		end
	end

	`TBS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntBits'(Depth), "Queue count exceeds its depth.")
	`TBS_ASSERT_IMP(a_no_overflow, push.count != 2'd0, has_room, "Tokens written without room.")
	`TBS_ASSERT_NXT(a_cnt_pop, pop && push.count == 2'd0, cnt_q == $past(cnt_q) - 1'b1,
		"A lone read did not lower the count by one.")

endmodule

// ----- hw/rtl/text_token_boundary_scanner_top.sv -----
// ----------------------------------------------------------------------------
// Text token boundary scanner
// Cuts text into words, strings and symbols, one byte a cycle unless stalled.
//
// Channel  Signals                         Direction  Transaction
// text     text_valid/text_stall           into       one text byte
// token    token_valid/token_stall         out of     one token record
//
// One byte is taken every cycle while text_stall is low; a byte that ends a
// word and also yields a symbol or the end record gives two tokens, which
// leave the queue one after the other. A token passes through the input
// register, then the four-entry token queue. Reset clears the scan mode,
// the offsets and the queue. token_stall backs up into the queue;
// text_stall rises while a byte waits in the input register and fewer than
// two queue entries are free.
`timescale 1ns / 1ps

module text_token_boundary_scanner_top #(
	parameter int OFFSET_BITS = tbs_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  text_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [2:0]  token_kind,
	output logic [31:0] token_start,
	output logic [31:0] token_length,
	output logic        last_of_run
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            accept;
	logic            process;
	logic            pop;
	logic            has_room;
	tbs_pkg::push_t  push;
	tbs_pkg::token_t head;

	assign process    = valid_s1 && has_room;
	assign text_stall = valid_s1 && !has_room;
	assign accept     = text_valid && !text_stall;
	assign pop        = token_valid && !token_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
		end
	end

	tbs_scan #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.process      (process),
		.text_byte_s1 (byte_s1),
		.push         (push)
	);

	tbs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.has_room  (has_room),
		.not_empty (token_valid),
		.head      (head)
	);

	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign last_of_run  = head.last;

endmodule
